// ===== design/dpsa_pkg.sv =====
// Package for the doubling pool slot allocator: beat types, command codes,
// status codes and the microcode program of the control sequencer.
// No dependencies.
`timescale 1ns / 1ps

package dpsa_pkg;

    localparam int SlotW     = 16;
    localparam int CountW    = 17;
    localparam int BaseW     = 13;
    localparam int SizeW     = 18;
    localparam int PoolW     = 5;
    localparam int FreeDepth = 1024;
    localparam int AddrW     = $clog2(FreeDepth);
    localparam int TopW      = AddrW + 1;
    localparam int StepW     = 5;

    localparam logic [CountW-1:0] MaxSlots = CountW'(65536);
    localparam logic [BaseW-1:0]  BaseMax  = BaseW'(4096);
    localparam logic [BaseW-1:0]  BaseRst  = BaseW'(16);
    localparam logic [TopW-1:0]   TopFull  = TopW'(FreeDepth);

    typedef enum logic [1:0] {
        CMD_CLAIM   = 2'd0,
        CMD_RELEASE = 2'd1,
        CMD_LOCATE  = 2'd2
    } cmd_t;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_EXHAUSTED = 2'd1;
    localparam logic [1:0] STATUS_FULL      = 2'd2;

    typedef struct packed {
        logic [1:0]       command;
        logic [SlotW-1:0] slot;
    } dpsa_in_t;

    typedef struct packed {
        logic [SlotW-1:0] granted_slot;
        logic             needs_pool;
        logic [SizeW-1:0] pool_size;
        logic [PoolW-1:0] pool_number;
        logic [SlotW-1:0] index_in_pool;
        logic [1:0]       status;
    } dpsa_out_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT_SLOT,
        OP_LOAD_FRESH,
        OP_POP,
        OP_LOAD_POP,
        OP_STEP,
        OP_FINISH,
        OP_PUSH,
        OP_SET_FULL,
        OP_SET_EXHAUST,
        OP_EMIT
    } op_t;

    typedef enum logic [3:0] {
        COND_ALWAYS,
        COND_ACCEPT,
        COND_IS_CLAIM,
        COND_IS_RELEASE,
        COND_IS_LOCATE,
        COND_STACK_NONEMPTY,
        COND_STACK_FULL,
        COND_EXHAUSTED,
        COND_SEARCH_MORE,
        COND_OUT_FREE
    } cond_t;

    typedef logic [StepW-1:0] step_t;

    typedef struct packed {
        logic  take;     // input ready during this step
        op_t   op;
        cond_t cond;
        step_t target;   // taken when cond holds
        logic  stay;     // hold the step when cond fails, else fall through
    } ctrl_t;

    localparam step_t STEP_WAIT     = 5'd0;
    localparam step_t STEP_DISP     = 5'd1;
    localparam step_t STEP_CLAIM    = 5'd5;
    localparam step_t STEP_POP      = 5'd8;
    localparam step_t STEP_SEARCH   = 5'd10;
    localparam step_t STEP_RELEASE  = 5'd12;
    localparam step_t STEP_FULL     = 5'd14;
    localparam step_t STEP_EXHAUST  = 5'd15;
    localparam step_t STEP_EMIT     = 5'd16;

    function automatic ctrl_t ucode(input step_t step);
        ctrl_t w;
        w = '{take: 1'b0, op: OP_NONE, cond: COND_ALWAYS, target: STEP_WAIT, stay: 1'b0};
        unique case (step)
            5'd0:  w = '{1'b1, OP_NONE,        COND_ACCEPT,         STEP_DISP,    1'b1};
            5'd1:  w = '{1'b0, OP_NONE,        COND_IS_CLAIM,       STEP_CLAIM,   1'b0};
            5'd2:  w = '{1'b0, OP_NONE,        COND_IS_RELEASE,     STEP_RELEASE, 1'b0};
            5'd3:  w = '{1'b0, OP_INIT_SLOT,   COND_IS_LOCATE,      STEP_SEARCH,  1'b0};
            5'd4:  w = '{1'b0, OP_NONE,        COND_ALWAYS,         STEP_EMIT,    1'b0};
            5'd5:  w = '{1'b0, OP_NONE,        COND_STACK_NONEMPTY, STEP_POP,     1'b0};
            5'd6:  w = '{1'b0, OP_NONE,        COND_EXHAUSTED,      STEP_EXHAUST, 1'b0};
            5'd7:  w = '{1'b0, OP_LOAD_FRESH,  COND_ALWAYS,         STEP_SEARCH,  1'b0};
            5'd8:  w = '{1'b0, OP_POP,         COND_ALWAYS,         5'd9,         1'b0};
            5'd9:  w = '{1'b0, OP_LOAD_POP,    COND_ALWAYS,         STEP_SEARCH,  1'b0};
            5'd10: w = '{1'b0, OP_STEP,        COND_SEARCH_MORE,    STEP_SEARCH,  1'b0};
            5'd11: w = '{1'b0, OP_FINISH,      COND_ALWAYS,         STEP_EMIT,    1'b0};
            5'd12: w = '{1'b0, OP_NONE,        COND_STACK_FULL,     STEP_FULL,    1'b0};
            5'd13: w = '{1'b0, OP_PUSH,        COND_ALWAYS,         STEP_EMIT,    1'b0};
            5'd14: w = '{1'b0, OP_SET_FULL,    COND_ALWAYS,         STEP_EMIT,    1'b0};
            5'd15: w = '{1'b0, OP_SET_EXHAUST, COND_ALWAYS,         STEP_EMIT,    1'b0};
            5'd16: w = '{1'b0, OP_EMIT,        COND_OUT_FREE,       STEP_WAIT,    1'b1};
            default: w = '{1'b0, OP_NONE,      COND_ALWAYS,         STEP_WAIT,    1'b0};
        endcase
        return w;
    endfunction

endpackage

// ===== design/doubling_pool_slot_allocator_core.sv =====
// A release pushes the slot onto the free stack unless it is full; a claim pops a freed
// slot or takes the next fresh one, then walks the doubling pools as a locate does; a
// claim that finds the slots used up reports exhausted. A result waits in the emit step
// while the output register is full. One item at a time: the next input beat is taken
// once the result is in the output register, which holds it while the next item runs.
// Reset (aresetn, synchronous, active low) empties the free stack and slot counter and sets
// pool_base to 16; the stack memory itself is not cleared.
`timescale 1ns / 1ps

module doubling_pool_slot_allocator_core
    import dpsa_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cfg_wr_en,
    input  logic [BaseW-1:0]    cfg_wr_data,
    input  logic                s_valid,
    output logic                s_ready,
    input  dpsa_in_t            s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output dpsa_out_t           m_data
);

    ctrl_t              ctrl;
    logic               s_fire;
    logic               cond_true;
    logic               out_free;
    logic               search_more;
    logic [SizeW:0]     span_sum;
    logic [SlotW-1:0]   idx;
    logic [SizeW-1:0]   eff_base;

    step_t              step_reg, step_next;
    logic [BaseW-1:0]   pool_base_reg;
    logic [TopW-1:0]    top_reg, top_next;
    logic [CountW-1:0]  count_reg, count_next;
    logic               m_valid_reg, m_valid_next;
    dpsa_out_t          m_data_reg, m_data_next;

    cmd_t               cmd_reg, cmd_next;
    logic [SlotW-1:0]   slot_reg, slot_next;
    logic [SlotW-1:0]   q_reg, q_next;
    logic [CountW-1:0]  covered_reg, covered_next;
    logic [SizeW-1:0]   sz_reg, sz_next;
    logic [PoolW-1:0]   k_reg, k_next;
    logic               fresh_reg, fresh_next;
    dpsa_out_t          res_reg, res_next;

    logic [SlotW-1:0]   stack_mem [FreeDepth];
    logic [SlotW-1:0]   rd_data_reg;
    logic [AddrW-1:0]   top_m1;

    assign ctrl     = ucode(step_reg);
    assign s_ready  = ctrl.take;
    assign s_fire   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign top_m1   = AddrW'(top_reg - TopW'(1));

    always_comb begin
        if (pool_base_reg == '0) begin
            eff_base = SizeW'(1);
        end else if (pool_base_reg > BaseMax) begin
            eff_base = SizeW'(BaseMax);
        end else begin
            eff_base = SizeW'(pool_base_reg);
        end
    end

    // The slot lies past the current pool when the pool's end does not exceed it.
    assign span_sum    = (SizeW + 1)'(covered_reg) + (SizeW + 1)'(sz_reg);
    assign search_more = span_sum <= (SizeW + 1)'(q_reg);
    assign idx         = SlotW'(q_reg - SlotW'(covered_reg));

    always_comb begin
        unique case (ctrl.cond)
            COND_ALWAYS:         cond_true = 1'b1;
            COND_ACCEPT:         cond_true = s_fire;
            COND_IS_CLAIM:       cond_true = cmd_reg == CMD_CLAIM;
            COND_IS_RELEASE:     cond_true = cmd_reg == CMD_RELEASE;
            COND_IS_LOCATE:      cond_true = cmd_reg == CMD_LOCATE;
            COND_STACK_NONEMPTY: cond_true = top_reg != '0;
            COND_STACK_FULL:     cond_true = top_reg == TopFull;
            COND_EXHAUSTED:      cond_true = count_reg == MaxSlots;
            COND_SEARCH_MORE:    cond_true = search_more;
            COND_OUT_FREE:       cond_true = out_free;
            default:             cond_true = 1'b0;
        endcase
    end

    always_comb begin
        step_next    = step_reg;
        top_next     = top_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        cmd_next     = cmd_reg;
        slot_next    = slot_reg;
        q_next       = q_reg;
        covered_next = covered_reg;
        sz_next      = sz_reg;
        k_next       = k_reg;
        fresh_next   = fresh_reg;
        res_next     = res_reg;

        if (cond_true) begin
            step_next = ctrl.target;
        end else if (!ctrl.stay) begin
            step_next = step_reg + step_t'(1);
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (s_fire) begin
            cmd_next   = cmd_t'(s_data.command);
            slot_next  = s_data.slot;
            fresh_next = 1'b0;
            res_next   = '0;
        end

        unique case (ctrl.op)
            OP_NONE: begin
            end
            OP_INIT_SLOT, OP_LOAD_FRESH, OP_LOAD_POP: begin
                covered_next = '0;
                sz_next      = eff_base;
                k_next       = '0;
                if (ctrl.op == OP_INIT_SLOT) begin
                    q_next = slot_reg;
                end else if (ctrl.op == OP_LOAD_FRESH) begin
                    q_next                = SlotW'(count_reg);
                    res_next.granted_slot = SlotW'(count_reg);
                    fresh_next            = 1'b1;
                    count_next            = count_reg + CountW'(1);
                end else begin
                    q_next                = rd_data_reg;
                    res_next.granted_slot = rd_data_reg;
                end
            end
            OP_POP: begin
                top_next = top_reg - TopW'(1);
            end
            OP_STEP: begin
                if (search_more) begin
                    covered_next = CountW'(span_sum);
                    sz_next      = sz_reg << 1;
                    k_next       = k_reg + PoolW'(1);
                end
            end
            OP_FINISH: begin
                if (cmd_reg == CMD_CLAIM) begin
                    res_next.needs_pool = fresh_reg && (idx == '0);
                    res_next.pool_size  = sz_reg;
                end else begin
                    res_next.pool_number   = k_reg;
                    res_next.index_in_pool = idx;
                end
            end
            OP_PUSH: begin
                top_next = top_reg + TopW'(1);
            end
            OP_SET_FULL: begin
                res_next.status = STATUS_FULL;
            end
            OP_SET_EXHAUST: begin
                res_next.status = STATUS_EXHAUSTED;
            end
            OP_EMIT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= STEP_WAIT;
            pool_base_reg <= BaseRst;
            top_reg       <= '0;
            count_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            step_reg    <= step_next;
            top_reg     <= top_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                pool_base_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg  <= m_data_next;
        cmd_reg     <= cmd_next;
        slot_reg    <= slot_next;
        q_reg       <= q_next;
        covered_reg <= covered_next;
        sz_reg      <= sz_next;
        k_reg       <= k_next;
        fresh_reg   <= fresh_next;
        res_reg     <= res_next;
    end

    // Free stack: the write port pushes at the fill count, the read port fetches
    // the entry below it in the pop step, the step before the popped value is used.
    always_ff @(posedge aclk) begin
        if (ctrl.op == OP_PUSH) begin
            stack_mem[top_reg[AddrW-1:0]] <= slot_reg;
        end
        if (ctrl.op == OP_POP) begin
            rd_data_reg <= stack_mem[top_m1];
        end
    end

`ifndef NO_ASSERTIONS
    a_top_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        top_reg <= TopFull)
        else $error("free stack fill count past its depth");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MaxSlots)
        else $error("slot counter past the slot limit");

    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        (ctrl.op == OP_POP) |-> (top_reg != '0))
        else $error("pop from an empty free stack");

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> (step_reg == STEP_DISP))
        else $error("sequencer did not dispatch an accepted beat");
`endif

endmodule

// ===== tb/doubling_pool_slot_allocator_core_tb.sv =====
// Self-checking testbench for doubling_pool_slot_allocator_core: a directed table,
// then random claim/release/locate and unused-command traffic checked against an in-bench slot allocator.
// Depends on dpsa_pkg and the core module only.
`timescale 1ns / 1ps

module doubling_pool_slot_allocator_core_tb
    import dpsa_pkg::*;
();

    localparam logic [1:0] CmdUnused   = 2'd3;
    localparam int         SearchLimit = 48;

    typedef enum {MIX_EVEN, MIX_FILL} mix_t;

    typedef struct {
        dpsa_in_t  beat;
        bit        known;
        dpsa_out_t want;
    } plan_row_t;

    logic                aclk        = 1'b0;
    logic                aresetn     = 1'b0;
    logic                cfg_wr_en   = 1'b0;
    logic [BaseW-1:0]    cfg_wr_data = '0;
    logic                s_valid     = 1'b0;
    logic                s_ready;
    dpsa_in_t            s_data      = '0;
    logic                m_valid;
    logic                m_ready     = 1'b0;
    dpsa_out_t           m_data;

    // Allocator state as the bench sees it.
    logic [BaseW-1:0]    pool_base_q = BaseRst;
    logic [SlotW-1:0]    free_slots [FreeDepth];
    int                  free_fill   = 0;
    int                  fresh_count = 0;

    dpsa_out_t           pending_outcomes [$];
    plan_row_t           directed_plan [$];
    int                  mismatches  = 0;
    bit                  idle_on     = 1'b1;
    int                  ready_hold  = 0;

    doubling_pool_slot_allocator_core DUT (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic longint unsigned active_base();
        longint unsigned b;
        b = pool_base_q;
        if (b == 0) b = 1;
        if (b > BaseMax) b = BaseMax;
        return b;
    endfunction

    // Walks the doubling pools until the one that holds slot q.
    function automatic void pool_of(input longint unsigned q, output int unsigned pool,
                                    output longint unsigned offs, output longint unsigned span);
        longint unsigned covered;
        covered = 0;
        span = active_base();
        pool = 0;
        while (pool < SearchLimit && covered + span <= q) begin
            covered += span;
            span <<= 1;
            pool++;
        end
        offs = q - covered;
    endfunction

    function automatic dpsa_out_t slot_outcome(input dpsa_in_t beat);
        dpsa_out_t       r;
        int unsigned     pool;
        longint unsigned offs, span;
        r = '0;
        unique case (beat.command)
            CMD_CLAIM: begin
                if (free_fill > 0) begin
                    free_fill--;
                    r.granted_slot = free_slots[free_fill];
                    pool_of(r.granted_slot, pool, offs, span);
                    r.pool_size = SizeW'(span);
                end else if (fresh_count < MaxSlots) begin
                    r.granted_slot = SlotW'(fresh_count);
                    pool_of(fresh_count, pool, offs, span);
                    r.needs_pool = (offs == 0);
                    r.pool_size = SizeW'(span);
                    fresh_count++;
                end else begin
                    r.status = STATUS_EXHAUSTED;
                end
            end
            CMD_RELEASE: begin
                if (free_fill < FreeDepth) begin
                    free_slots[free_fill] = beat.slot;
                    free_fill++;
                end else begin
                    r.status = STATUS_FULL;
                end
            end
            CMD_LOCATE: begin
                pool_of(beat.slot, pool, offs, span);
                r.pool_number = PoolW'(pool);
                r.index_in_pool = SlotW'(offs);
            end
            default: ;
        endcase
        return r;
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 55) return 0;
        if (roll < 90) return $urandom_range(1, 3);
        if (roll < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Slots near pool boundaries matter most, so a share of picks lands there.
    function automatic logic [SlotW-1:0] pick_slot();
        int     roll;
        longint v;
        roll = $urandom_range(0, 99);
        if (roll < 40) return SlotW'($urandom);
        if (roll < 60) return SlotW'($urandom_range(0, 300));
        if (roll < 63) return '1;
        if (roll < 65) return '0;
        v = longint'(active_base()) * ((longint'(1) << $urandom_range(0, 16)) - 1)
            + int'($urandom_range(0, 2)) - 1;
        if (v < 0 || v > 65535) return SlotW'($urandom);
        return SlotW'(v);
    endfunction

    function automatic dpsa_in_t random_request(input mix_t mix);
        dpsa_in_t beat;
        int       roll, claim_lim, release_lim, locate_lim;
        unique case (mix)
            MIX_FILL: begin
                claim_lim = 8;  release_lim = 88; locate_lim = 97;
            end
            default: begin
                claim_lim = 40; release_lim = 70; locate_lim = 95;
            end
        endcase
        roll = $urandom_range(0, 99);
        if (roll < claim_lim) beat.command = CMD_CLAIM;
        else if (roll < release_lim) beat.command = CMD_RELEASE;
        else if (roll < locate_lim) beat.command = CMD_LOCATE;
        else beat.command = CmdUnused;
        beat.slot = pick_slot();
        return beat;
    endfunction

    function automatic void plan(input logic [1:0] cmd, input logic [SlotW-1:0] slot);
        plan_row_t row;
        row.beat.command = cmd;
        row.beat.slot = slot;
        row.known = 1'b0;
        row.want = '0;
        directed_plan.push_back(row);
    endfunction

    function automatic void plan_known(input logic [1:0] cmd, input logic [SlotW-1:0] slot,
                                       input int unsigned granted, input bit needs,
                                       input int unsigned size, input int unsigned pool,
                                       input int unsigned offs, input logic [1:0] status);
        plan_row_t row;
        row.beat.command = cmd;
        row.beat.slot = slot;
        row.known = 1'b1;
        row.want.granted_slot = SlotW'(granted);
        row.want.needs_pool = needs;
        row.want.pool_size = SizeW'(size);
        row.want.pool_number = PoolW'(pool);
        row.want.index_in_pool = SlotW'(offs);
        row.want.status = status;
        directed_plan.push_back(row);
    endfunction

    function automatic void same_field(input string name, input int unsigned want,
                                       input int unsigned got);
        if (want != got) begin
            $display("%0t ns: %s expected %0d got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    function automatic void check_outcome(input dpsa_out_t got);
        dpsa_out_t want;
        if (pending_outcomes.size() == 0) begin
            $display("%0t ns: result beat with nothing outstanding, granted_slot %0d status %0d",
                     $time, got.granted_slot, got.status);
            mismatches++;
            return;
        end
        want = pending_outcomes.pop_front();
        same_field("granted_slot", want.granted_slot, got.granted_slot);
        same_field("needs_pool", want.needs_pool, got.needs_pool);
        same_field("pool_size", want.pool_size, got.pool_size);
        same_field("pool_number", want.pool_number, got.pool_number);
        same_field("index_in_pool", want.index_in_pool, got.index_in_pool);
        same_field("status", want.status, got.status);
    endfunction

    // Valid is only dropped when a gap follows, so back-to-back beats keep it high.
    task automatic send_beat(input dpsa_in_t beat, input bit known, input dpsa_out_t want);
        int        gap;
        dpsa_out_t outcome;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= beat;
        do @(posedge aclk); while (!s_ready);
        outcome = slot_outcome(beat);
        pending_outcomes.push_back(known ? want : outcome);
    endtask

    task automatic write_pool_base(input logic [BaseW-1:0] value);
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_outcomes.size() != 0);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        pool_base_q = value;
    endtask

    task automatic run_random(input int count, input mix_t mix);
        for (int i = 0; i < count; i++) begin
            if (i % 64 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_beat(random_request(mix), 1'b0, '0);
        end
    endtask

    // Result side: checks each beat and stalls ready in random bursts.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) check_outcome(m_data);
        if (ready_hold > 0) begin
            m_ready <= 1'b0;
            ready_hold--;
        end else begin
            m_ready <= 1'b1;
            if (idle_on) ready_hold = pick_gap();
        end
    end

    initial begin
        logic [BaseW-1:0] next_base;
        dpsa_in_t         beat;

        // Directed rows run with the reset base of 16.
        plan_known(CMD_LOCATE, 16'd0, 0, 0, 0, 0, 0, STATUS_OK);
        plan_known(CMD_CLAIM, 16'd0, 0, 1, 16, 0, 0, STATUS_OK);
        plan_known(CMD_CLAIM, 16'd0, 1, 0, 16, 0, 0, STATUS_OK);
        plan_known(CMD_LOCATE, 16'd15, 0, 0, 0, 0, 15, STATUS_OK);
        plan_known(CMD_LOCATE, 16'd16, 0, 0, 0, 1, 0, STATUS_OK);
        plan_known(CMD_LOCATE, 16'hFFFF, 0, 0, 0, 12, 15, STATUS_OK);
        plan_known(CMD_RELEASE, 16'hFFFF, 0, 0, 0, 0, 0, STATUS_OK);
        plan_known(CMD_CLAIM, 16'd0, 65535, 0, 65536, 0, 0, STATUS_OK);
        plan_known(CMD_RELEASE, 16'd0, 0, 0, 0, 0, 0, STATUS_OK);
        plan_known(CMD_RELEASE, 16'd1, 0, 0, 0, 0, 0, STATUS_OK);
        plan_known(CMD_CLAIM, 16'd0, 1, 0, 16, 0, 0, STATUS_OK);
        plan_known(CMD_CLAIM, 16'd0, 0, 0, 16, 0, 0, STATUS_OK);
        plan_known(CMD_CLAIM, 16'd0, 2, 0, 16, 0, 0, STATUS_OK);
        plan_known(CmdUnused, 16'hFFFF, 0, 0, 0, 0, 0, STATUS_OK);
        plan_known(CmdUnused, 16'd0, 0, 0, 0, 0, 0, STATUS_OK);
        plan(CMD_LOCATE, 16'h5555);
        plan(CMD_LOCATE, 16'hAAAA);
        plan_known(CMD_RELEASE, 16'hAAAA, 0, 0, 0, 0, 0, STATUS_OK);
        plan_known(CMD_RELEASE, 16'h5555, 0, 0, 0, 0, 0, STATUS_OK);
        plan(CMD_CLAIM, 16'd0);
        plan(CMD_CLAIM, 16'd0);
        plan_known(CMD_LOCATE, 16'd47, 0, 0, 0, 1, 31, STATUS_OK);
        plan_known(CMD_LOCATE, 16'd48, 0, 0, 0, 2, 0, STATUS_OK);
        plan_known(CMD_CLAIM, 16'hFFFF, 3, 0, 16, 0, 0, STATUS_OK);

        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (directed_plan[i])
            send_beat(directed_plan[i].beat, directed_plan[i].known, directed_plan[i].want);

        // Base sweep, including values the block has to clamp.
        for (int ph = 0; ph < 8; ph++) begin
            unique case (ph)
                0: next_base = 13'd1;
                1: next_base = 13'd4096;
                2: next_base = 13'd0;
                3: next_base = 13'd8191;
                4: next_base = 13'd4097;
                5: next_base = 13'd3;
                6: next_base = BaseW'($urandom_range(1, 4096));
                default: next_base = BaseW'($urandom_range(0, 8191));
            endcase
            write_pool_base(next_base);
            run_random(50, MIX_EVEN);
        end

        // Fill the free stack with releases, bounce off the full stack, then mix again.
        write_pool_base(13'd5);
        idle_on = 1'b1;
        beat.command = CMD_RELEASE;
        while (free_fill < FreeDepth) begin
            beat.slot = pick_slot();
            send_beat(beat, 1'b0, '0);
        end
        run_random(40, MIX_FILL);
        idle_on = 1'b1;
        run_random(60, MIX_EVEN);

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_outcomes.size() != 0);
        repeat (30) @(posedge aclk);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
